>>> design/iqpd_pkg.sv
package iqpd_pkg;

    localparam logic [15:0] LEN_24 = 16'd1444;
    localparam logic [15:0] LEN_16 = 16'd1028;

    localparam int POS_W = 11;
    localparam logic [POS_W-1:0] POS_LAST_24 = POS_W'(LEN_24 - 16'd1);
    localparam logic [POS_W-1:0] POS_LAST_16 = POS_W'(LEN_16 - 16'd1);
    localparam logic [POS_W-1:0] POS_SEQ_LO  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SEQ_HI  = POS_W'(3);
    localparam logic [POS_W-1:0] HDR_BYTES   = POS_W'(4);

    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PHASE_LAST_24 = PHASE_W'(5);
    localparam logic [PHASE_W-1:0] PHASE_LAST_16 = PHASE_W'(3);

    typedef enum logic [1:0] {
        MODE_IGNORE = 2'd0,
        MODE_24     = 2'd1,
        MODE_16     = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_of_packet;
        logic [15:0] packet_length;
    } t_in_req;

    typedef struct packed {
        logic signed [23:0] i_sample;
        logic signed [23:0] q_sample;
        logic               last_in_packet;
        logic signed [31:0] missed_total;
    } t_out_req;

    typedef struct packed {
        logic        valid;
        logic [15:0] seq;
    } t_seq_chk;

    typedef struct packed {
        logic               emit;
        logic signed [23:0] i_sample;
        logic signed [23:0] q_sample;
        logic               last_in_packet;
    } t_pair;

endpackage

>>> design/iqpd_seq.sv
module iqpd_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iqpd_pkg::t_seq_chk  i_chk,
    output logic signed [31:0]  o_missed
);

    logic [15:0] r_expected;
    logic [15:0] n_expected;
    logic [31:0] r_missed;
    logic [31:0] n_missed;
    logic [15:0] seq_inc;
    logic [31:0] gap;

    always_comb begin
        seq_inc    = i_chk.seq + 16'd1;
        gap        = {{16{i_chk.seq[15]}}, i_chk.seq} - {{16{r_expected[15]}}, r_expected};
        n_expected = r_expected;
        n_missed   = r_missed;
        if (i_chk.valid) begin
            // zero restarts the check, expected skips zero
            if ((i_chk.seq != 16'd0) && (i_chk.seq != r_expected)) begin
                n_missed = r_missed + gap;
            end
            n_expected = (seq_inc == 16'd0) ? 16'd1 : seq_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= 16'd0;
            r_missed   <= 32'd0;
        end else begin
            r_expected <= n_expected;
            r_missed   <= n_missed;
        end
    end

    assign o_missed = signed'(r_missed);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_chk.valid) |-> (r_expected != 16'd0))
        else $error("expected sequence zero after a check");

endmodule

>>> design/iqpd_frame.sv
module iqpd_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  iqpd_pkg::t_in_req   i_req,
    output iqpd_pkg::t_seq_chk  o_chk,
    output iqpd_pkg::t_pair     o_pair
);

    localparam int PW = iqpd_pkg::POS_W;
    localparam int KW = iqpd_pkg::PHASE_W;

    iqpd_pkg::t_mode r_mode;
    iqpd_pkg::t_mode n_mode;
    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   n_pos;
    logic [KW-1:0]   r_phase;
    logic [KW-1:0]   n_phase;
    logic [39:0]     r_held;
    logic [39:0]     n_held;
    logic [7:0]      r_seq_lo;
    logic [7:0]      n_seq_lo;

    iqpd_pkg::t_mode mode_eff;
    logic [PW-1:0]   pos_eff;
    logic [KW-1:0]   phase_eff;
    logic [39:0]     held_eff;
    logic            active;
    logic            is24;
    logic            is_last;
    logic            in_hdr;
    logic [KW-1:0]   phase_last;

    // state seen by this byte, after any start of packet
    always_comb begin
        if (i_req.start_of_packet) begin
            pos_eff   = '0;
            phase_eff = '0;
            held_eff  = '0;
            if (i_req.packet_length == iqpd_pkg::LEN_24) begin
                mode_eff = iqpd_pkg::MODE_24;
            end else if (i_req.packet_length == iqpd_pkg::LEN_16) begin
                mode_eff = iqpd_pkg::MODE_16;
            end else begin
                mode_eff = iqpd_pkg::MODE_IGNORE;
            end
        end else begin
            pos_eff   = r_pos;
            phase_eff = r_phase;
            held_eff  = r_held;
            mode_eff  = r_mode;
        end
        active     = (mode_eff != iqpd_pkg::MODE_IGNORE);
        is24       = (mode_eff == iqpd_pkg::MODE_24);
        is_last    = (pos_eff == (is24 ? iqpd_pkg::POS_LAST_24 : iqpd_pkg::POS_LAST_16));
        in_hdr     = (pos_eff < iqpd_pkg::HDR_BYTES);
        phase_last = is24 ? iqpd_pkg::PHASE_LAST_24 : iqpd_pkg::PHASE_LAST_16;
    end

    // next state
    always_comb begin
        n_mode   = mode_eff;
        n_pos    = pos_eff;
        n_phase  = phase_eff;
        n_held   = held_eff;
        n_seq_lo = r_seq_lo;
        if (active) begin
            if (is_last) begin
                n_mode = iqpd_pkg::MODE_IGNORE;
            end else begin
                n_pos = pos_eff + PW'(1);
            end
            if (in_hdr) begin
                if (pos_eff == iqpd_pkg::POS_SEQ_LO) begin
                    n_seq_lo = i_req.data_byte;
                end
            end else begin
                n_held  = {held_eff[31:0], i_req.data_byte};
                n_phase = (phase_eff == phase_last) ? '0 : phase_eff + KW'(1);
            end
        end
    end

    // outputs
    always_comb begin
        o_chk.valid = active && (pos_eff == iqpd_pkg::POS_SEQ_HI);
        o_chk.seq   = {i_req.data_byte, r_seq_lo};
        o_pair.emit = active && !in_hdr && (phase_eff == phase_last);
        o_pair.last_in_packet = is_last;
        if (is24) begin
            o_pair.i_sample = signed'({held_eff[23:16], held_eff[31:24], held_eff[39:32]});
            o_pair.q_sample = signed'({i_req.data_byte, held_eff[7:0], held_eff[15:8]});
        end else begin
            o_pair.i_sample = signed'({held_eff[15:8], held_eff[23:16], 8'h00});
            o_pair.q_sample = signed'({i_req.data_byte, held_eff[7:0], 8'h00});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= iqpd_pkg::MODE_IGNORE;
            r_pos    <= '0;
            r_phase  <= '0;
            r_held   <= '0;
            r_seq_lo <= '0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_seq_lo <= n_seq_lo;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == iqpd_pkg::MODE_24) |-> (r_phase <= iqpd_pkg::PHASE_LAST_24))
        else $error("pair phase out of range in 24-bit mode");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == iqpd_pkg::MODE_16) |-> (r_phase <= iqpd_pkg::PHASE_LAST_16))
        else $error("pair phase out of range in 16-bit mode");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == iqpd_pkg::MODE_16) |-> (r_pos <= iqpd_pkg::POS_LAST_16))
        else $error("byte position beyond 16-bit packet");

endmodule

>>> design/iq_packet_deframer.sv
// iq packet deframer
// input channel: one packet byte per request with start flag and packet length;
//   length 1444 selects 24-bit pairs, 1028 selects 16-bit pairs, others dropped
// output channel: one request per completed i/q pair, 8 fractional bits,
//   with last-in-packet flag and the running missed-packet total
// path: an accepted byte passes the input register, one pass of logic and the
//   result register; the byte that completes a pair carries it to the output
// throughput: one byte per cycle while the result receiver does not stall
// reset: synchronous, active low; clears byte position, format, sequence
//   state and missed total, both stages empty
// receiver stall: the result register holds; the input register takes one
//   more byte, then o_in_ready drops until the result is taken
module iq_packet_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  iqpd_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output iqpd_pkg::t_out_req o_out_req
);

    logic               r_in_valid;
    iqpd_pkg::t_in_req  r_in;
    logic               r_out_valid;
    iqpd_pkg::t_out_req r_out;

    logic               step;
    iqpd_pkg::t_seq_chk chk;
    iqpd_pkg::t_seq_chk seq_chk;
    iqpd_pkg::t_pair    pair;
    logic signed [31:0] missed;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    assign seq_chk.valid = chk.valid && step;
    assign seq_chk.seq   = chk.seq;

    iqpd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in),
        .o_chk   (chk),
        .o_pair  (pair)
    );

    iqpd_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_chk    (seq_chk),
        .o_missed (missed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= pair.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && pair.emit) begin
            r_out.i_sample       <= pair.i_sample;
            r_out.q_sample       <= pair.q_sample;
            r_out.last_in_packet <= pair.last_in_packet;
            r_out.missed_total   <= missed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && pair.emit) |=> o_out_valid)
        else $error("emitted pair did not reach the output");

endmodule

>>> verif/tb_iq_packet_deframer.sv
module tb_iq_packet_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500_000;

    typedef struct {
        iqpd_pkg::t_in_req req;
        bit                hold;
    } t_byte_item;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_TOGGLE
    } t_rdy_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    iqpd_pkg::t_in_req  i_in_req = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    iqpd_pkg::t_out_req o_out_req;

    iq_packet_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    always #5 i_clk = ~i_clk;

    // deframer state mirror
    logic [10:0]     byte_pos;
    iqpd_pkg::t_mode fmt;
    logic [7:0]      seq_lo;
    logic [15:0]     exp_seq;
    logic [31:0]     gap_sum;
    logic [39:0]     held_bytes;

    t_byte_item         pending_bytes[$];
    iqpd_pkg::t_out_req expected_pairs[$];
    t_byte_item         nxt_item;
    iqpd_pkg::t_out_req want;

    logic [15:0] next_seq = 16'd0;
    bit          in_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    t_rdy_mode   rdy_mode = RDY_ALWAYS;
    int          rdy_left = 0;
    int          fail_cnt = 0;
    int          bytes_in = 0;
    int          pairs_out = 0;
    int          frames_done = 0;
    int          cycle_cnt = 0;

    function automatic void deframe_byte(input iqpd_pkg::t_in_req req);
        logic [10:0]        p;
        logic [39:0]        h;
        logic [15:0]        seq;
        logic [15:0]        frame_len;
        logic [23:0]        iv;
        logic [23:0]        qv;
        bit                 wide;
        bit                 is_last;
        int                 pb;
        iqpd_pkg::t_out_req pair;
        if (req.start_of_packet) begin
            byte_pos = '0;
            held_bytes = '0;
            if (req.packet_length == iqpd_pkg::LEN_24) fmt = iqpd_pkg::MODE_24;
            else if (req.packet_length == iqpd_pkg::LEN_16) fmt = iqpd_pkg::MODE_16;
            else fmt = iqpd_pkg::MODE_IGNORE;
        end
        if (fmt == iqpd_pkg::MODE_IGNORE) return;
        wide = (fmt == iqpd_pkg::MODE_24);
        frame_len = wide ? iqpd_pkg::LEN_24 : iqpd_pkg::LEN_16;
        pb = wide ? 6 : 4;
        p = byte_pos;
        is_last = ({5'd0, p} + 16'd1 == frame_len);
        if (is_last) fmt = iqpd_pkg::MODE_IGNORE;
        else byte_pos = p + 11'd1;
        if (p < 11'd4) begin
            if (p == 11'd2) begin
                seq_lo = req.data_byte;
            end else if (p == 11'd3) begin
                seq = {req.data_byte, seq_lo};
                if (seq == 16'd0) exp_seq = 16'd0;
                if (seq != exp_seq) begin
                    gap_sum = gap_sum + ({{16{seq[15]}}, seq} - {{16{exp_seq[15]}}, exp_seq});
                    exp_seq = seq;
                end
                exp_seq = exp_seq + 16'd1;
                if (exp_seq == 16'd0) exp_seq = 16'd1;
            end
            return;
        end
        h = held_bytes;
        held_bytes = {h[31:0], req.data_byte};
        if ((int'(p) - 4) % pb != pb - 1) return;
        if (wide) begin
            iv = {h[23:16], h[31:24], h[39:32]};
            qv = {req.data_byte, h[7:0], h[15:8]};
        end else begin
            iv = {h[15:8], h[23:16], 8'h00};
            qv = {req.data_byte, h[7:0], 8'h00};
        end
        pair.i_sample = iv;
        pair.q_sample = qv;
        pair.last_in_packet = is_last;
        pair.missed_total = gap_sum;
        expected_pairs.push_back(pair);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_seq();
        case ($urandom_range(0, 9))
            6: return 16'd0;
            7: return 16'($urandom);
            8: return 16'hFFFF;
            9: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return next_seq;
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] data, input bit sop, input logic [15:0] len,
                             input bit hold);
        t_byte_item item;
        item.req.data_byte = data;
        item.req.start_of_packet = sop;
        item.req.packet_length = len;
        item.hold = hold;
        pending_bytes.push_back(item);
    endtask

    task automatic send_packet(input logic [15:0] len, input int nbytes, input bit hold);
        logic [15:0] seq;
        logic [7:0]  data;
        seq = pick_seq();
        for (int idx = 0; idx < nbytes; idx++) begin
            if (idx == 2) data = seq[7:0];
            else if (idx == 3) data = seq[15:8];
            else data = rand_byte();
            push_byte(data, idx == 0, (idx == 0) ? len : 16'($urandom), hold && idx == 0);
        end
        if (nbytes >= 4 && (len == iqpd_pkg::LEN_24 || len == iqpd_pkg::LEN_16)) begin
            next_seq = seq + 16'd1;
            if (next_seq == 16'd0) next_seq = 16'd1;
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_bytes.size() != 0 &&
                         !(pending_bytes[0].hold && expected_pairs.size() != 0)) begin
                nxt_item = pending_bytes.pop_front();
                i_in_req <= nxt_item.req;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                              : $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (rdy_left == 0) begin
                rdy_mode <= t_rdy_mode'($urandom_range(0, 3));
                rdy_left <= $urandom_range(20, 200);
            end else begin
                rdy_left <= rdy_left - 1;
            end
            case (rdy_mode)
                RDY_ALWAYS: i_out_ready <= 1'b1;
                RDY_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:    i_out_ready <= !i_out_ready;
            endcase
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_pos = '0;
            fmt = iqpd_pkg::MODE_IGNORE;
            seq_lo = '0;
            exp_seq = '0;
            gap_sum = '0;
            held_bytes = '0;
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                pairs_out++;
                if (o_out_req.last_in_packet) frames_done++;
                if (expected_pairs.size() == 0) begin
                    $error("unexpected pair: i_sample %0d q_sample %0d",
                           o_out_req.i_sample, o_out_req.q_sample);
                    fail_cnt++;
                end else begin
                    want = expected_pairs.pop_front();
                    if (o_out_req.i_sample !== want.i_sample) begin
                        $error("i_sample: expected %0d, actual %0d",
                               want.i_sample, o_out_req.i_sample);
                        fail_cnt++;
                    end
                    if (o_out_req.q_sample !== want.q_sample) begin
                        $error("q_sample: expected %0d, actual %0d",
                               want.q_sample, o_out_req.q_sample);
                        fail_cnt++;
                    end
                    if (o_out_req.last_in_packet !== want.last_in_packet) begin
                        $error("last_in_packet: expected %0b, actual %0b",
                               want.last_in_packet, o_out_req.last_in_packet);
                        fail_cnt++;
                    end
                    if (o_out_req.missed_total !== want.missed_total) begin
                        $error("missed_total: expected %0d, actual %0d",
                               want.missed_total, o_out_req.missed_total);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                bytes_in++;
                deframe_byte(i_in_req);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout with %0d pairs outstanding", expected_pairs.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int          dir_cnt;
        int          trig16;
        int          sel;
        bit          done16;
        logic [15:0] len;

        // stray bytes before any start, then unknown lengths
        push_byte(8'hA5, 1'b0, 16'hFFFF, 1'b0);
        push_byte(8'h5A, 1'b0, 16'h0000, 1'b0);
        push_byte(8'hFF, 1'b1, 16'h0000, 1'b0);
        push_byte(8'h00, 1'b1, 16'hFFFF, 1'b0);
        push_byte(8'h11, 1'b0, iqpd_pkg::LEN_16, 1'b0);
        // 16-bit frame, sequence zero, extreme pair, then a partial pair
        push_byte(8'h01, 1'b1, iqpd_pkg::LEN_16, 1'b0);
        push_byte(8'h02, 1'b0, 16'h0000, 1'b0);
        push_byte(8'h00, 1'b0, 16'h0000, 1'b0);
        push_byte(8'h00, 1'b0, 16'h0000, 1'b0);
        push_byte(8'h00, 1'b0, 16'hFFFF, 1'b0);
        push_byte(8'h80, 1'b0, 16'hFFFF, 1'b0);
        push_byte(8'hFF, 1'b0, 16'hFFFF, 1'b0);
        push_byte(8'h7F, 1'b0, 16'hFFFF, 1'b0);
        push_byte(8'h12, 1'b0, 16'h0000, 1'b0);
        push_byte(8'h34, 1'b0, 16'h0000, 1'b0);
        // early start: 24-bit frame, negative sequence gap, extreme pair
        push_byte(8'hFF, 1'b1, iqpd_pkg::LEN_24, 1'b0);
        push_byte(8'hFF, 1'b0, 16'h0000, 1'b0);
        push_byte(8'h00, 1'b0, 16'h0000, 1'b0);
        push_byte(8'h80, 1'b0, 16'h0000, 1'b0);
        push_byte(8'h00, 1'b0, 16'hFFFF, 1'b0);
        push_byte(8'h00, 1'b0, 16'hFFFF, 1'b0);
        push_byte(8'h80, 1'b0, 16'hFFFF, 1'b0);
        push_byte(8'hFF, 1'b0, 16'h0000, 1'b0);
        push_byte(8'hFF, 1'b0, 16'h0000, 1'b0);
        push_byte(8'h7F, 1'b0, 16'h0000, 1'b0);
        next_seq = 16'h8001;
        dir_cnt = pending_bytes.size();

        // random part, the first request waits for the directed pairs to drain
        trig16 = $urandom_range(0, 100);
        done16 = 1'b0;
        send_packet(iqpd_pkg::LEN_16, $urandom_range(4, 30), 1'b1);
        while (pending_bytes.size() - dir_cnt < 850 || !done16) begin
            if (!done16 && pending_bytes.size() - dir_cnt >= trig16) begin
                send_packet(iqpd_pkg::LEN_16, int'(iqpd_pkg::LEN_16),
                            $urandom_range(0, 3) == 0);
                done16 = 1'b1;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 50) begin
                    send_packet($urandom_range(0, 1) ? iqpd_pkg::LEN_24 : iqpd_pkg::LEN_16,
                                $urandom_range(1, 40), 1'b0);
                end else if (sel < 75) begin
                    do begin
                        if ($urandom_range(0, 1))
                            len = ($urandom_range(0, 1) ? iqpd_pkg::LEN_24
                                                        : iqpd_pkg::LEN_16) +
                                  16'($urandom_range(0, 2)) - 16'd1;
                        else
                            len = 16'($urandom);
                    end while (len == iqpd_pkg::LEN_24 || len == iqpd_pkg::LEN_16);
                    send_packet(len, $urandom_range(1, 20), 1'b0);
                end else begin
                    repeat ($urandom_range(1, 6))
                        push_byte(rand_byte(), 1'b0, 16'($urandom), 1'b0);
                end
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_pairs.size() != 0) begin
            $error("%0d pairs never arrived", expected_pairs.size());
            fail_cnt++;
        end

        $display("sent %0d packet bytes, checked %0d sample pairs, %0d complete packets",
                 bytes_in, pairs_out, frames_done);
        $display("final missed-packet total %0d", $signed(gap_sum));
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
design/iqpd_pkg.sv
design/iqpd_seq.sv
design/iqpd_frame.sv
design/iq_packet_deframer.sv
verif/tb_iq_packet_deframer.sv
